// ===== rtl/core/bgc_pkg.sv =====
`default_nettype none

package bgc_pkg;

    // Default number of button slots.
    localparam int NUM_PINS_DEFAULT = 32;

    // Configuration port geometry: four 32-bit registers, word aligned.
    localparam int PADDR_W = 4;

    localparam logic [1:0] REG_ENABLE_MASK     = 2'd0;
    localparam logic [1:0] REG_ACTIVE_LOW_MASK = 2'd1;
    localparam logic [1:0] REG_LONG_HOLD_MS    = 2'd2;
    localparam logic [1:0] REG_DBL_WINDOW_MS   = 2'd3;

    localparam logic [31:0] ENABLE_MASK_RESET     = 32'h0000_0000;
    localparam logic [31:0] ACTIVE_LOW_MASK_RESET = 32'hFFFF_FFFF;
    localparam logic [31:0] LONG_HOLD_MS_RESET    = 32'd500;
    localparam logic [31:0] DBL_WINDOW_MS_RESET   = 32'd250;

    // Request opcodes.
    localparam logic [1:0] OP_LEVEL = 2'd0;
    localparam logic [1:0] OP_POLL  = 2'd1;
    localparam logic [1:0] OP_QUERY = 2'd2;

    // Event kinds carried by a result.
    localparam logic [2:0] EV_PRESS   = 3'd0;
    localparam logic [2:0] EV_RELEASE = 3'd1;
    localparam logic [2:0] EV_LONG    = 3'd2;
    localparam logic [2:0] EV_SHORT   = 3'd3;
    localparam logic [2:0] EV_DOUBLE  = 3'd4;
    localparam logic [2:0] EV_QUERY   = 3'd5;

    typedef struct packed {
        logic [1:0]  opcode;
        logic [4:0]  pin;
        logic        level;
        logic [31:0] now_ms;
    } req_t;

    typedef struct packed {
        logic [4:0] event_pin;
        logic [2:0] event_kind;
        logic       is_pressed;
        logic       last;
    } res_t;

    typedef struct packed {
        logic [31:0] enable_mask;
        logic [31:0] active_low_mask;
        logic [31:0] long_hold_ms;
        logic [31:0] dbl_window_ms;
    } cfg_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic load;
        logic level_eval;
        logic query;
        logic emit_double;
        logic sweep_step;
        logic flush;
    } cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic op_level;
        logic op_poll;
        logic op_query;
        logic need_double;
        logic sweep_done;
    } stat_t;

endpackage

`default_nettype wire

// ===== rtl/core/bgc_regs.sv =====
`default_nettype none

module bgc_regs
(
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire logic                        psel,
    input  wire logic                        penable,
    input  wire logic                        pwrite,
    input  wire logic [bgc_pkg::PADDR_W-1:0] paddr,
    input  wire logic [31:0]                 pwdata,
    output logic      [31:0]                 prdata,
    output bgc_pkg::cfg_t                    cfg
);

    bgc_pkg::cfg_t cfg_reg;
    logic          wr_en;

    assign wr_en = psel && penable && pwrite;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.enable_mask     <= bgc_pkg::ENABLE_MASK_RESET;
            cfg_reg.active_low_mask <= bgc_pkg::ACTIVE_LOW_MASK_RESET;
            cfg_reg.long_hold_ms    <= bgc_pkg::LONG_HOLD_MS_RESET;
            cfg_reg.dbl_window_ms   <= bgc_pkg::DBL_WINDOW_MS_RESET;
        end
        else if (wr_en)
        begin
            unique case (paddr[3:2])
                bgc_pkg::REG_ENABLE_MASK:     cfg_reg.enable_mask     <= pwdata;
                bgc_pkg::REG_ACTIVE_LOW_MASK: cfg_reg.active_low_mask <= pwdata;
                bgc_pkg::REG_LONG_HOLD_MS:    cfg_reg.long_hold_ms    <= pwdata;
                bgc_pkg::REG_DBL_WINDOW_MS:   cfg_reg.dbl_window_ms   <= pwdata;
            endcase
        end
    end

    always_comb
    begin
        unique case (paddr[3:2])
            bgc_pkg::REG_ENABLE_MASK:     prdata = cfg_reg.enable_mask;
            bgc_pkg::REG_ACTIVE_LOW_MASK: prdata = cfg_reg.active_low_mask;
            bgc_pkg::REG_LONG_HOLD_MS:    prdata = cfg_reg.long_hold_ms;
            bgc_pkg::REG_DBL_WINDOW_MS:   prdata = cfg_reg.dbl_window_ms;
        endcase
    end

    assign cfg = cfg_reg;

endmodule

`default_nettype wire

// ===== rtl/core/bgc_ctrl.sv =====
`default_nettype none

module bgc_ctrl
(
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire logic           start,
    input  wire bgc_pkg::stat_t stat,
    output logic                busy,
    output bgc_pkg::cmd_t       cmd
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_DECODE,
        S_DOUBLE,
        S_SWEEP,
        S_FLUSH
    } state_t;

    state_t state_reg;
    state_t state_next;

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        unique case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    cmd.load   = 1'b1;
                    state_next = S_DECODE;
                end
            end
            S_DECODE:
            begin
                if (stat.op_level)
                begin
                    cmd.level_eval = 1'b1;
                    state_next     = stat.need_double ? S_DOUBLE : S_IDLE;
                end
                else if (stat.op_query)
                begin
                    cmd.query  = 1'b1;
                    state_next = S_IDLE;
                end
                else if (stat.op_poll)
                begin
                    state_next = S_SWEEP;
                end
                else
                begin
                    state_next = S_IDLE;
                end
            end
            S_DOUBLE:
            begin
                cmd.emit_double = 1'b1;
                state_next      = S_IDLE;
            end
            S_SWEEP:
            begin
                cmd.sweep_step = 1'b1;
                if (stat.sweep_done)
                begin
                    state_next = S_FLUSH;
                end
            end
            S_FLUSH:
            begin
                cmd.flush  = 1'b1;
                state_next = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    assign busy = (state_reg != S_IDLE);

`ifndef SYNTHESIS
    // The Double result is only ever scheduled by the release evaluation.
    a_double_after_decode: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_DOUBLE |-> $past(state_reg) == S_DECODE)
        else $error("double emission not preceded by decode");

    // A request taken while idle is always decoded in the following cycle.
    a_start_decodes: assert property (@(posedge clk) disable iff (!rst_n)
        start && !busy |=> state_reg == S_DECODE)
        else $error("accepted request was not decoded");
`endif

endmodule

`default_nettype wire

// ===== rtl/core/bgc_datapath.sv =====
`default_nettype none

module bgc_datapath
#(
    parameter int NUM_PINS = bgc_pkg::NUM_PINS_DEFAULT
)
(
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire bgc_pkg::req_t  request,
    input  wire bgc_pkg::cfg_t  cfg,
    input  wire bgc_pkg::cmd_t  cmd,
    output bgc_pkg::stat_t      stat,
    output logic                result_valid,
    output bgc_pkg::res_t       result
);

    localparam int IDX_W = (NUM_PINS > 1) ? $clog2(NUM_PINS) : 1;
    localparam int CNT_W = $clog2(NUM_PINS + 1);

    typedef enum logic [1:0] {
        PH_IDLE,
        PH_DOWN,
        PH_WAIT,
        PH_DOWN2
    } phase_t;

    // Per-slot control state, cleared at reset.
    phase_t              phase_reg [NUM_PINS];
    logic [NUM_PINS-1:0] long_reg;
    logic [NUM_PINS-1:0] pressed_reg;

    // One timestamp per slot: the press time while held, the release time while
    // waiting for a second press. Its value is used only once it has been written.
    logic [31:0] stamp_mem [NUM_PINS];
    logic [31:0] stamp_q_reg;

    bgc_pkg::req_t      item_reg;
    logic [CNT_W-1:0]   cnt_reg;
    logic [IDX_W-1:0]   eval_idx_reg;
    logic               eval_vld_reg;
    bgc_pkg::res_t      pend_reg;
    logic               pend_valid_reg;
    bgc_pkg::res_t      result_reg;
    bgc_pkg::res_t      result_next;
    logic               result_valid_reg;
    logic               result_valid_next;

    logic [IDX_W-1:0]   pin_idx;
    logic               pin_en;
    logic               pin_prs;
    phase_t             pin_ph;
    logic               pin_long;
    logic               stamp_we;
    logic               sweep_rd;

    logic [6:0]         q_wide;
    logic               q_en;
    phase_t             q_ph;
    logic [31:0]        elapsed;
    logic [31:0]        thresh;
    logic               over;
    logic               long_hit;
    logic               short_hit;
    bgc_pkg::res_t      hit_res;

    always_comb
    begin
        pin_idx  = IDX_W'(item_reg.pin);
        pin_en   = ({2'b00, item_reg.pin} < 7'(NUM_PINS)) && cfg.enable_mask[item_reg.pin];
        pin_prs  = cfg.active_low_mask[item_reg.pin] ? !item_reg.level : item_reg.level;
        pin_ph   = phase_reg[pin_idx];
        pin_long = long_reg[pin_idx];

        stamp_we = 1'b0;
        if (cmd.level_eval && pin_en)
        begin
            if ((pin_ph == PH_IDLE || pin_ph == PH_WAIT) && pin_prs)
            begin
                stamp_we = 1'b1;
            end
            else if (pin_ph == PH_DOWN && !pin_prs)
            begin
                stamp_we = 1'b1;
            end
        end

        sweep_rd = cmd.sweep_step && (cnt_reg != CNT_W'(NUM_PINS));

        // Evaluation of the slot whose timestamp was read in the previous cycle.
        q_wide  = 7'(eval_idx_reg);
        q_en    = (q_wide < 7'd32) && cfg.enable_mask[q_wide[4:0]];
        q_ph    = phase_reg[eval_idx_reg];
        elapsed = item_reg.now_ms - stamp_q_reg;
        thresh  = (q_ph == PH_WAIT) ? cfg.dbl_window_ms : cfg.long_hold_ms;
        over    = (elapsed >= thresh);

        long_hit  = cmd.sweep_step && eval_vld_reg && q_en
                    && (q_ph == PH_DOWN || q_ph == PH_DOWN2)
                    && pressed_reg[eval_idx_reg] && !long_reg[eval_idx_reg] && over;
        short_hit = cmd.sweep_step && eval_vld_reg && q_en && (q_ph == PH_WAIT) && over;

        hit_res.event_pin  = q_wide[4:0];
        hit_res.event_kind = long_hit ? bgc_pkg::EV_LONG : bgc_pkg::EV_SHORT;
        hit_res.is_pressed = 1'b0;
        hit_res.last       = 1'b0;

        stat.op_level    = (item_reg.opcode == bgc_pkg::OP_LEVEL);
        stat.op_poll     = (item_reg.opcode == bgc_pkg::OP_POLL);
        stat.op_query    = (item_reg.opcode == bgc_pkg::OP_QUERY);
        stat.need_double = pin_en && (pin_ph == PH_DOWN2) && !pin_prs && !pin_long;
        stat.sweep_done  = (cnt_reg == CNT_W'(NUM_PINS));
    end

    // Result selection. Sweep hits go through a one-deep holding register so that
    // the final one can be marked once the sweep has ended.
    always_comb
    begin
        result_next                = result_reg;
        result_next.event_pin      = item_reg.pin;
        result_next.is_pressed     = 1'b0;
        result_next.last           = 1'b1;
        result_valid_next          = 1'b0;

        if (cmd.level_eval && pin_en)
        begin
            case (pin_ph)
                PH_IDLE, PH_WAIT:
                begin
                    result_next.event_kind = bgc_pkg::EV_PRESS;
                    result_valid_next      = pin_prs;
                end
                PH_DOWN:
                begin
                    result_next.event_kind = bgc_pkg::EV_RELEASE;
                    result_valid_next      = !pin_prs;
                end
                default:
                begin
                    result_next.event_kind = bgc_pkg::EV_RELEASE;
                    result_next.last       = pin_long;
                    result_valid_next      = !pin_prs;
                end
            endcase
        end
        else if (cmd.emit_double)
        begin
            result_next.event_kind = bgc_pkg::EV_DOUBLE;
            result_valid_next      = 1'b1;
        end
        else if (cmd.query)
        begin
            result_next.event_kind = bgc_pkg::EV_QUERY;
            result_next.is_pressed = pin_en && pressed_reg[pin_idx];
            result_valid_next      = 1'b1;
        end
        else if ((long_hit || short_hit) && pend_valid_reg)
        begin
            result_next       = pend_reg;
            result_valid_next = 1'b1;
        end
        else if (cmd.flush && pend_valid_reg)
        begin
            result_next      = pend_reg;
            result_next.last = 1'b1;
            result_valid_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < NUM_PINS; i++)
            begin
                phase_reg[i] <= PH_IDLE;
            end
            long_reg         <= '0;
            pressed_reg      <= '0;
            cnt_reg          <= '0;
            eval_vld_reg     <= 1'b0;
            pend_valid_reg   <= 1'b0;
            result_valid_reg <= 1'b0;
        end
        else
        begin
            result_valid_reg <= result_valid_next;

            if (cmd.load)
            begin
                cnt_reg        <= '0;
                eval_vld_reg   <= 1'b0;
                pend_valid_reg <= 1'b0;
            end

            if (cmd.level_eval && pin_en)
            begin
                pressed_reg[pin_idx] <= pin_prs;
                case (pin_ph)
                    PH_IDLE, PH_WAIT:
                    begin
                        if (pin_prs)
                        begin
                            phase_reg[pin_idx] <= (pin_ph == PH_IDLE) ? PH_DOWN : PH_DOWN2;
                            long_reg[pin_idx]  <= 1'b0;
                        end
                    end
                    PH_DOWN:
                    begin
                        if (!pin_prs)
                        begin
                            phase_reg[pin_idx] <= pin_long ? PH_IDLE : PH_WAIT;
                        end
                    end
                    default:
                    begin
                        if (!pin_prs)
                        begin
                            phase_reg[pin_idx] <= PH_IDLE;
                        end
                    end
                endcase
            end

            if (cmd.sweep_step)
            begin
                eval_vld_reg <= sweep_rd;
                if (sweep_rd)
                begin
                    cnt_reg <= cnt_reg + CNT_W'(1);
                end
                if (long_hit)
                begin
                    long_reg[eval_idx_reg] <= 1'b1;
                end
                if (short_hit)
                begin
                    phase_reg[eval_idx_reg] <= PH_IDLE;
                end
                if (long_hit || short_hit)
                begin
                    pend_valid_reg <= 1'b1;
                end
            end

            if (cmd.flush)
            begin
                pend_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            item_reg <= request;
        end
        if (stamp_we)
        begin
            stamp_mem[pin_idx] <= item_reg.now_ms;
        end
        if (sweep_rd)
        begin
            stamp_q_reg  <= stamp_mem[cnt_reg[IDX_W-1:0]];
            eval_idx_reg <= cnt_reg[IDX_W-1:0];
        end
        if (long_hit || short_hit)
        begin
            pend_reg <= hit_res;
        end
        result_reg <= result_next;
    end

    assign result_valid = result_valid_reg;
    assign result       = result_reg;

`ifndef SYNTHESIS
    // The held sweep hit only changes during a sweep, its flush or a new request.
    a_pend_quiet: assert property (@(posedge clk) disable iff (!rst_n)
        !cmd.sweep_step && !cmd.flush && !cmd.load |=> $stable(pend_valid_reg))
        else $error("held sweep result changed outside a sweep");

    // Nothing is left held once the sweep has been flushed.
    a_flush_empties: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.flush |=> !pend_valid_reg)
        else $error("held sweep result survived the flush");

    // A flushed hit is the final result of its poll.
    a_flush_last: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.flush && pend_valid_reg |=> result_valid_reg && result_reg.last)
        else $error("flushed sweep result not marked last");
`endif

endmodule

`default_nettype wire

// ===== rtl/core/button_gesture_classifier.sv =====
// Channel     Ports                                       Direction  Handshake
// ----------  ------------------------------------------  ---------  ------------------------
// request     start, busy, request                        in         start && !busy
// result      result_valid, result                        out        one-cycle strobe
// config      psel, penable, pwrite, paddr, pwdata,       in/out     psel && penable && pwrite
//             prdata, pready
//
// A level-change request is decoded and its result registered; a Double that follows
// the Release is given from its own state. A query is handled the same way. A poll
// request walks the slots through the shared timestamp memory at one slot per cycle,
// and a flush state then gives its final result, if there is one, as busy falls.
// Reset (rst_n, asynchronous, active low) puts every slot in the idle phase and loads the
// register defaults; the timestamp memory needs no clearing. The receiver cannot stall:
// each result is shown for exactly one cycle.

`default_nettype none

module button_gesture_classifier
#(
    parameter int NUM_PINS = bgc_pkg::NUM_PINS_DEFAULT
)
(
    input  wire logic                        clk,
    input  wire logic                        rst_n,

    // Request channel
    input  wire logic                        start,
    output logic                             busy,
    input  wire bgc_pkg::req_t               request,

    // Result channel
    output logic                             result_valid,
    output bgc_pkg::res_t                    result,

    // Configuration port
    input  wire logic                        psel,
    input  wire logic                        penable,
    input  wire logic                        pwrite,
    input  wire logic [bgc_pkg::PADDR_W-1:0] paddr,
    input  wire logic [31:0]                 pwdata,
    output logic      [31:0]                 prdata,
    output logic                             pready
);

    bgc_pkg::cfg_t  cfg;
    bgc_pkg::cmd_t  cmd;
    bgc_pkg::stat_t stat;

    // The configuration port never inserts wait states.
    assign pready = 1'b1;

    // Register file for the enable mask, the polarity mask and the two time thresholds.
    bgc_regs u_regs
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .cfg     (cfg)
    );

    // The controller sequences each request: decode, the optional Double, and the
    // slot sweep of a poll followed by a flush that marks the poll's last result.
    bgc_ctrl u_ctrl
    (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .stat  (stat),
        .busy  (busy),
        .cmd   (cmd)
    );

    // The datapath holds the per-slot gesture state, the timestamp memory and the
    // result register. During a sweep one slot's timestamp is read while the slot read
    // in the previous cycle is checked against its threshold.
    bgc_datapath
    #(
        .NUM_PINS (NUM_PINS)
    )
    u_datapath
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .request      (request),
        .cfg          (cfg),
        .cmd          (cmd),
        .stat         (stat),
        .result_valid (result_valid),
        .result       (result)
    );

endmodule

`default_nettype wire

// ===== tb/button_gesture_classifier_checker.sv =====
`default_nettype none

module button_gesture_classifier_checker
(
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire logic                        start,
    input  wire logic                        busy,
    input  wire bgc_pkg::req_t               request,
    input  wire logic                        result_valid,
    input  wire bgc_pkg::res_t               result,
    input  wire logic                        psel,
    input  wire logic                        penable,
    input  wire logic                        pwrite,
    input  wire logic [bgc_pkg::PADDR_W-1:0] paddr,
    input  wire logic [31:0]                 pwdata,
    input  wire logic [31:0]                 prdata,
    input  wire logic                        pready,
    output int unsigned                      mismatches,
    output int unsigned                      pending
);
    import bgc_pkg::*;

    typedef enum logic [1:0] {
        PHASE_IDLE  = 2'd0,
        PHASE_DOWN  = 2'd1,
        PHASE_WAIT  = 2'd2,
        PHASE_DOWN2 = 2'd3
    } slot_phase_t;

    logic [31:0] enable_bits;
    logic [31:0] active_low_bits;
    logic [31:0] hold_limit_ms;
    logic [31:0] window_ms;

    slot_phase_t phase_of [32];
    logic [31:0] pressed_at [32];
    logic [31:0] released_at [32];
    logic        long_done [32];
    logic        held [32];

    res_t        gesture_q [$];
    res_t        want;
    logic [31:0] reg_value;
    int unsigned fault_count = 0;
    int unsigned pending_count = 0;

    assign mismatches = fault_count;
    assign pending    = pending_count;

    task automatic report_mismatch(input string msg);
        $display("[%0t] mismatch: %s", $realtime, msg);
        fault_count++;
    endtask

    function automatic void queue_gesture(input logic [4:0] pin, input logic [2:0] kind,
                                          input logic prs);
        res_t ev;
        ev.event_pin  = pin;
        ev.event_kind = kind;
        ev.is_pressed = prs;
        ev.last       = 1'b0;
        gesture_q.push_back(ev);
    endfunction

    // Works out the events one request causes and updates the slot state.
    function automatic void classify_request(input req_t rq);
        int          start_len;
        logic        now_pressed;
        logic [31:0] elapsed;
        res_t        tail;
        start_len = gesture_q.size();
        case (rq.opcode)
            OP_LEVEL:
            begin
                if (enable_bits[rq.pin])
                begin
                    now_pressed = active_low_bits[rq.pin] ? !rq.level : rq.level;
                    held[rq.pin] = now_pressed;
                    case (phase_of[rq.pin])
                        PHASE_IDLE, PHASE_WAIT:
                        begin
                            if (now_pressed)
                            begin
                                phase_of[rq.pin] = (phase_of[rq.pin] == PHASE_IDLE) ?
                                                   PHASE_DOWN : PHASE_DOWN2;
                                pressed_at[rq.pin] = rq.now_ms;
                                long_done[rq.pin]  = 1'b0;
                                queue_gesture(rq.pin, EV_PRESS, 1'b0);
                            end
                        end
                        PHASE_DOWN:
                        begin
                            if (!now_pressed)
                            begin
                                released_at[rq.pin] = rq.now_ms;
                                phase_of[rq.pin] = long_done[rq.pin] ? PHASE_IDLE : PHASE_WAIT;
                                queue_gesture(rq.pin, EV_RELEASE, 1'b0);
                            end
                        end
                        default:
                        begin
                            if (!now_pressed)
                            begin
                                queue_gesture(rq.pin, EV_RELEASE, 1'b0);
                                if (!long_done[rq.pin])
                                    queue_gesture(rq.pin, EV_DOUBLE, 1'b0);
                                phase_of[rq.pin] = PHASE_IDLE;
                            end
                        end
                    endcase
                end
            end
            OP_POLL:
            begin
                for (int q = 0; q < 32; q++)
                begin
                    if (enable_bits[q])
                    begin
                        if (phase_of[q] == PHASE_DOWN || phase_of[q] == PHASE_DOWN2)
                        begin
                            elapsed = rq.now_ms - pressed_at[q];
                            if (held[q] && !long_done[q] && elapsed >= hold_limit_ms)
                            begin
                                long_done[q] = 1'b1;
                                queue_gesture(q[4:0], EV_LONG, 1'b0);
                            end
                        end
                        else if (phase_of[q] == PHASE_WAIT)
                        begin
                            elapsed = rq.now_ms - released_at[q];
                            if (elapsed >= window_ms)
                            begin
                                queue_gesture(q[4:0], EV_SHORT, 1'b0);
                                phase_of[q] = PHASE_IDLE;
                            end
                        end
                    end
                end
            end
            OP_QUERY:
                queue_gesture(rq.pin, EV_QUERY, enable_bits[rq.pin] && held[rq.pin]);
            default:
                ;
        endcase
        if (gesture_q.size() > start_len)
        begin
            tail = gesture_q.pop_back();
            tail.last = 1'b1;
            gesture_q.push_back(tail);
        end
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            enable_bits     = ENABLE_MASK_RESET;
            active_low_bits = ACTIVE_LOW_MASK_RESET;
            hold_limit_ms   = LONG_HOLD_MS_RESET;
            window_ms       = DBL_WINDOW_MS_RESET;
            for (int p = 0; p < 32; p++)
            begin
                phase_of[p]    = PHASE_IDLE;
                pressed_at[p]  = '0;
                released_at[p] = '0;
                long_done[p]   = 1'b0;
                held[p]        = 1'b0;
            end
            gesture_q.delete();
            pending_count = 0;
        end
        else
        begin
            if (result_valid)
            begin
                if (gesture_q.size() == 0)
                    report_mismatch($sformatf("unexpected result pin %0d kind %0d",
                                              result.event_pin, result.event_kind));
                else
                begin
                    want = gesture_q.pop_front();
                    if (result.event_pin !== want.event_pin)
                        report_mismatch($sformatf("event_pin %0d, wanted %0d",
                                                  result.event_pin, want.event_pin));
                    if (result.event_kind !== want.event_kind)
                        report_mismatch($sformatf("event_kind %0d, wanted %0d (pin %0d)",
                                                  result.event_kind, want.event_kind,
                                                  want.event_pin));
                    if (result.is_pressed !== want.is_pressed)
                        report_mismatch($sformatf("is_pressed %b, wanted %b (pin %0d)",
                                                  result.is_pressed, want.is_pressed,
                                                  want.event_pin));
                    if (result.last !== want.last)
                        report_mismatch($sformatf("last %b, wanted %b (pin %0d kind %0d)",
                                                  result.last, want.last, want.event_pin,
                                                  want.event_kind));
                end
            end

            if (psel && penable && pready)
            begin
                case (paddr[3:2])
                    REG_ENABLE_MASK:     reg_value = enable_bits;
                    REG_ACTIVE_LOW_MASK: reg_value = active_low_bits;
                    REG_LONG_HOLD_MS:    reg_value = hold_limit_ms;
                    default:             reg_value = window_ms;
                endcase
                if (pwrite)
                begin
                    case (paddr[3:2])
                        REG_ENABLE_MASK:     enable_bits     = pwdata;
                        REG_ACTIVE_LOW_MASK: active_low_bits = pwdata;
                        REG_LONG_HOLD_MS:    hold_limit_ms   = pwdata;
                        default:             window_ms       = pwdata;
                    endcase
                end
                else if (prdata !== reg_value)
                    report_mismatch($sformatf("register %0d read %h, wanted %h",
                                              paddr[3:2], prdata, reg_value));
            end

            if (start && !busy)
                classify_request(request);

            pending_count = gesture_q.size();
        end
    end

endmodule

`default_nettype wire

// ===== tb/button_gesture_classifier_test.sv =====
`default_nettype none

module button_gesture_classifier_test;
    import bgc_pkg::*;

    // Opcode 3 has no meaning; the block must swallow it without a result.
    localparam logic [1:0] OP_UNUSED = 2'd3;

    // A poll walks every slot before its final result, so this margin covers
    // the longest stretch of work that may follow the last expected result.
    localparam int SETTLE_CYCLES = 40;

    // Cycles without any request, result or register access before the run is
    // abandoned. The slowest quiet stretch is a settle period plus a sender gap
    // plus a poll that gives nothing.
    localparam int QUIET_LIMIT = 2000;

    localparam int PHASE_COUNT     = 6;
    localparam int ITEMS_PER_PHASE = 80;

    logic        clk = 1'b0;
    logic        rst_n;
    logic        start;
    logic        busy;
    req_t        request;
    logic        result_valid;
    res_t        result;
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [PADDR_W-1:0] paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;

    int unsigned mismatches;
    int unsigned pending;
    int unsigned quiet_cycles;

    // The sender's notion of time, and the raw level last driven on each pin,
    // so that level changes mostly form genuine press and release sequences.
    logic [31:0] clock_ms;
    logic        raw_level [32];
    logic [31:0] cur_enable;
    bit          gaps_on;

    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    button_gesture_classifier i_dut
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .start        (start),
        .busy         (busy),
        .request      (request),
        .result_valid (result_valid),
        .result       (result),
        .psel         (psel),
        .penable      (penable),
        .pwrite       (pwrite),
        .paddr        (paddr),
        .pwdata       (pwdata),
        .prdata       (prdata),
        .pready       (pready)
    );

    button_gesture_classifier_checker i_checker
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .start        (start),
        .busy         (busy),
        .request      (request),
        .result_valid (result_valid),
        .result       (result),
        .psel         (psel),
        .penable      (penable),
        .pwrite       (pwrite),
        .paddr        (paddr),
        .pwdata       (pwdata),
        .prdata       (prdata),
        .pready       (pready),
        .mismatches   (mismatches),
        .pending      (pending)
    );

    // Watchdog: any accepted request, result or register access counts as
    // progress. A hang anywhere shows up as a long run of quiet cycles.
    always @(posedge clk)
    begin
        if (!rst_n || (start && !busy) || result_valid || (psel && penable))
            quiet_cycles <= 0;
        else if (quiet_cycles >= QUIET_LIMIT)
        begin
            $display("** button_gesture_classifier: FAILED **");
            $finish;
        end
        else
            quiet_cycles <= quiet_cycles + 1;
    end

    // One register access: a setup cycle, an access cycle, then a cycle with the
    // port released so that psel never falls and rises within one time step.
    task automatic reg_access(input bit is_write, input logic [1:0] index,
                              input logic [31:0] data);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= is_write;
        paddr   <= {index, 2'b00};
        pwdata  <= data;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready)
            @(posedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        @(posedge clk);
    endtask

    task automatic set_thresholds(input logic [31:0] en, input logic [31:0] act_low,
                                  input logic [31:0] hold_ms, input logic [31:0] win_ms);
        reg_access(1'b1, REG_ENABLE_MASK, en);
        reg_access(1'b1, REG_ACTIVE_LOW_MASK, act_low);
        reg_access(1'b1, REG_LONG_HOLD_MS, hold_ms);
        reg_access(1'b1, REG_DBL_WINDOW_MS, win_ms);
        cur_enable = en;
    endtask

    task automatic read_back_registers();
        reg_access(1'b0, REG_ENABLE_MASK, '0);
        reg_access(1'b0, REG_ACTIVE_LOW_MASK, '0);
        reg_access(1'b0, REG_LONG_HOLD_MS, '0);
        reg_access(1'b0, REG_DBL_WINDOW_MS, '0);
    endtask

    // Presents one request stamped with the current time and returns at the
    // rising edge that accepts it. busy is looked at on the falling edge, where
    // it is stable, so acceptance never hangs on event ordering at the edge.
    // start stays high on return; the next request either follows at once or
    // a random gap drops it first.
    task automatic send_item(input logic [1:0] op, input logic [4:0] pin, input logic lvl);
        req_t rq;
        rq.opcode = op;
        rq.pin    = pin;
        rq.level  = lvl;
        rq.now_ms = clock_ms;
        if (op == OP_LEVEL)
            raw_level[pin] = lvl;
        if (gaps_on && $urandom_range(0, 3) == 0)
        begin
            start <= 1'b0;
            repeat ($urandom_range(1, 5))
                @(posedge clk);
        end
        start   <= 1'b1;
        request <= rq;
        @(negedge clk);
        while (busy)
            @(negedge clk);
        @(posedge clk);
    endtask

    // Holds off the sender until every predicted result has been seen and the
    // block has had time to finish any request that gives no result.
    task automatic wait_for_quiet();
        start <= 1'b0;
        @(negedge clk);
        while (pending != 0 || busy)
            @(negedge clk);
        repeat (SETTLE_CYCLES)
            @(posedge clk);
    endtask

    // One random request. Level changes mostly flip the pin's level, so that
    // slots walk through press, release, double and long sequences; the rest
    // are polls, queries, the unused opcode and wild time jumps.
    task automatic random_item(input int unsigned step_max);
        int unsigned pick;
        logic [4:0]  pin;
        pick = $urandom_range(0, 99);
        clock_ms = clock_ms + $urandom_range(0, step_max);
        pin = 5'($urandom_range(0, 31));
        if (!cur_enable[pin] && $urandom_range(0, 3) != 0)
            pin = 5'($urandom_range(0, 31));
        if (pick < 55)
        begin
            if ($urandom_range(0, 7) != 0)
                send_item(OP_LEVEL, pin, !raw_level[pin]);
            else
                send_item(OP_LEVEL, pin, raw_level[pin]);
        end
        else if (pick < 80)
            send_item(OP_POLL, pin, 1'($urandom_range(0, 1)));
        else if (pick < 93)
            send_item(OP_QUERY, pin, 1'($urandom_range(0, 1)));
        else if (pick < 97)
            send_item(OP_UNUSED, pin, 1'($urandom_range(0, 1)));
        else
        begin
            clock_ms = $urandom();
            send_item(OP_LEVEL, pin, 1'($urandom_range(0, 1)));
        end
    endtask

    initial
    begin
        int unsigned step_max;

        rst_n   <= 1'b0;
        start   <= 1'b0;
        request <= '0;
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        paddr   <= '0;
        pwdata  <= '0;
        clock_ms = '0;
        cur_enable = ENABLE_MASK_RESET;
        gaps_on = 1'b1;
        for (int p = 0; p < 32; p++)
            raw_level[p] = 1'b1;

        repeat (11)
            @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Reset values must read back before anything is written.
        read_back_registers();

        // With every slot disabled a query answers not pressed, a level change
        // is dropped, a poll finds nothing and the unused opcode is swallowed.
        send_item(OP_QUERY, 5'd3, 1'b0);
        send_item(OP_LEVEL, 5'd3, 1'b0);
        send_item(OP_UNUSED, 5'd17, 1'b1);
        send_item(OP_POLL, 5'd0, 1'b0);
        wait_for_quiet();

        // Low half active low, high half active high.
        reg_access(1'b1, REG_ENABLE_MASK, 32'h0000_0000);
        set_thresholds(32'hFFFF_FFFF, 32'h0000_FFFF, 32'd500, 32'd250);
        read_back_registers();

        // Pin 0: press, repeated level without a phase change, query, then a
        // Long that is reported only once, and a release after Long that goes
        // straight back to idle.
        clock_ms = 32'd1000;
        send_item(OP_LEVEL, 5'd0, 1'b0);
        send_item(OP_LEVEL, 5'd0, 1'b0);
        send_item(OP_QUERY, 5'd0, 1'b0);
        clock_ms = 32'd1600;
        send_item(OP_POLL, 5'd0, 1'b0);
        send_item(OP_POLL, 5'd0, 1'b0);
        clock_ms = 32'd1700;
        send_item(OP_LEVEL, 5'd0, 1'b1);

        // Pin 31, active high: a double click ends in Release then Double.
        clock_ms = 32'd2000;
        send_item(OP_LEVEL, 5'd31, 1'b1);
        clock_ms = 32'd2100;
        send_item(OP_LEVEL, 5'd31, 1'b0);
        clock_ms = 32'd2200;
        send_item(OP_LEVEL, 5'd31, 1'b1);
        clock_ms = 32'd2250;
        send_item(OP_LEVEL, 5'd31, 1'b0);

        // Pin 5: a single click whose window runs out gives Short on a poll.
        clock_ms = 32'd3000;
        send_item(OP_LEVEL, 5'd5, 1'b0);
        clock_ms = 32'd3100;
        send_item(OP_LEVEL, 5'd5, 1'b1);
        clock_ms = 32'd3400;
        send_item(OP_POLL, 5'd0, 1'b0);

        // Pin 20: the second press is held into a Long, so its release gives
        // no Double.
        clock_ms = 32'd4000;
        send_item(OP_LEVEL, 5'd20, 1'b1);
        clock_ms = 32'd4050;
        send_item(OP_LEVEL, 5'd20, 1'b0);
        clock_ms = 32'd4100;
        send_item(OP_LEVEL, 5'd20, 1'b1);
        clock_ms = 32'd4700;
        send_item(OP_POLL, 5'd0, 1'b0);
        clock_ms = 32'd4800;
        send_item(OP_LEVEL, 5'd20, 1'b0);

        // Pin 9: the hold spans the wrap of the millisecond counter.
        clock_ms = 32'hFFFF_FF00;
        send_item(OP_LEVEL, 5'd9, 1'b0);
        clock_ms = 32'h0000_0200;
        send_item(OP_POLL, 5'd0, 1'b0);
        send_item(OP_QUERY, 5'd31, 1'b1);
        send_item(OP_LEVEL, 5'd9, 1'b1);

        // Random phases, each under its own register setting, including the
        // zero and all-ones thresholds. Registers change only once the block
        // has gone quiet.
        for (int phase = 0; phase < PHASE_COUNT; phase++)
        begin
            wait_for_quiet();
            case (phase)
                0:
                begin
                    set_thresholds(32'hFFFF_FFFF, $urandom(), 32'd500, 32'd250);
                    step_max = 150;
                end
                1:
                begin
                    set_thresholds($urandom(), $urandom(), $urandom_range(0, 1000),
                                   $urandom_range(0, 600));
                    step_max = 250;
                end
                2:
                begin
                    set_thresholds(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'd0, 32'd0);
                    step_max = 20;
                end
                3:
                begin
                    set_thresholds($urandom() | 32'h1, 32'h0000_0000, 32'hFFFF_FFFF,
                                   32'hFFFF_FFFF);
                    clock_ms = $urandom();
                    step_max = 2000;
                end
                4:
                begin
                    set_thresholds($urandom(), $urandom(), $urandom_range(1, 100),
                                   $urandom_range(1, 100));
                    step_max = 60;
                end
                default:
                begin
                    // Final stretch: no gaps from the sender, and every slot driven to its pressed
                    // level at once so that a single poll can report Long on all of them.
                    gaps_on = 1'b0;
                    set_thresholds(32'hFFFF_FFFF, 32'h0000_0000, 32'd500, 32'd250);
                    step_max = 150;
                    for (int p = 0; p < 32; p++)
                        send_item(OP_LEVEL, p[4:0], 1'b1);
                    clock_ms = clock_ms + 32'd600;
                    send_item(OP_POLL, 5'd0, 1'b0);
                end
            endcase
            read_back_registers();

            for (int n = 0; n < ITEMS_PER_PHASE; n++)
            begin
                // Once per phase, except in the gap-free final stretch, the
                // sender waits for the block to drain completely.
                if (n == ITEMS_PER_PHASE / 2 && gaps_on)
                    wait_for_quiet();
                random_item(step_max);
            end
        end

        wait_for_quiet();
        if (mismatches == 0 && pending == 0)
            $display("** button_gesture_classifier: PASSED **");
        else
            $display("** button_gesture_classifier: FAILED **");
        $finish;
    end

endmodule

`default_nettype wire
